>>> hdl/bcsm_pkg.sv
`timescale 1ns / 1ps
package bcsm_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int BLOCK_BITS = 32;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int REFS_W = 16;
  localparam int TIME_W = 32;
  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef enum logic [2:0] {
    COND_EMPTY = 3'd0, COND_ALLOCATED = 3'd1, COND_LOADING = 3'd2,
    COND_CLEAN = 3'd3, COND_DIRTY = 3'd4
  } cond_t;

  typedef enum logic [2:0] {
    REQ_LOAD = 3'd0, REQ_RELEASE = 3'd1, REQ_MARK_DIRTY = 3'd2,
    REQ_FILL_DONE = 3'd3, REQ_WRITE_DONE = 3'd4, REQ_DROP = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_HIT_READY = 3'd0, ST_HIT_LOADING = 3'd1, ST_FILL_EMPTY = 3'd2,
    ST_FILL_EVICT = 3'd3, ST_NEED_SYNC = 3'd4, ST_NO_ROOM = 3'd5,
    ST_OK = 3'd6, ST_ERROR = 3'd7
  } status_t;

  typedef struct packed {
    logic scan_clear;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;
endpackage

>>> hdl/bcsm_ctrl.sv
`timescale 1ns / 1ps
module bcsm_ctrl
  import bcsm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_busy,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_SCAN = 3'b010, S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.scan_clear = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

>>> hdl/bcsm_dp.sv
`timescale 1ns / 1ps
module bcsm_dp
  import bcsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [2:0]            in_req,
  input  logic [31:0]           in_block,
  input  logic [3:0]            in_sel,
  input  logic [31:0]           in_time,
  output logic [2:0]            res_status,
  output logic [3:0]            res_slot,
  output logic                  res_vv,
  output logic [31:0]           res_vb,
  output logic [15:0]           res_refs
);
  cond_t                 cond_r [NUM_SLOTS];
  logic [BLOCK_BITS-1:0] blk_r  [NUM_SLOTS];
  logic [REFS_W-1:0]     refs_r [NUM_SLOTS];
  logic [TIME_W-1:0]     last_r [NUM_SLOTS];

  logic [2:0]            req_r;
  logic [BLOCK_BITS-1:0] bn_r;
  logic [3:0]            sel_r;
  logic [TIME_W-1:0]     now_r;

  logic [SLOT_W-1:0] idx_r;
  logic              hit_f_r, emp_f_r, vic_f_r, dty_f_r;
  logic [SLOT_W-1:0] hit_r, emp_r, vic_r, dty_r;
  logic [TIME_W-1:0] old_r;

  logic [SLOT_W-1:0] i;
  cond_t             c;
  assign i = idx_r;
  assign c = cond_r[i];
  assign sts.scan_last = (idx_r == SLOT_W'(NUM_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      req_r <= in_req;
      bn_r <= BLOCK_BITS'(in_block);
      sel_r <= in_sel;
      now_r <= in_time;
      idx_r <= '0;
      hit_f_r <= 1'b0; emp_f_r <= 1'b0; vic_f_r <= 1'b0; dty_f_r <= 1'b0;
      hit_r <= '0; emp_r <= '0; vic_r <= '0; dty_r <= '0; old_r <= '0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_last) idx_r <= idx_r + 1'b1;
      if (c == COND_EMPTY) begin
        if (!emp_f_r) begin emp_f_r <= 1'b1; emp_r <= i; end
      end else begin
        if (!hit_f_r && blk_r[i] == bn_r) begin hit_f_r <= 1'b1; hit_r <= i; end
        if (refs_r[i] == '0) begin
          if (c == COND_CLEAN && (!vic_f_r || last_r[i] < old_r)) begin
            vic_f_r <= 1'b1; vic_r <= i; old_r <= last_r[i];
          end
          if (c == COND_DIRTY && !dty_f_r) begin dty_f_r <= 1'b1; dty_r <= i; end
        end
      end
    end
  end

  logic              sel_ok;
  logic [SLOT_W-1:0] s;
  logic [SLOT_W-1:0] ld;
  logic [REFS_W-1:0] hr;
  assign sel_ok = ({28'd0, sel_r} < 32'(NUM_SLOTS));
  assign s = SLOT_W'(sel_r);
  assign ld = hit_f_r ? hit_r : (emp_f_r ? emp_r : vic_r);
  assign hr = (refs_r[hit_r] < REFS_MAX) ? refs_r[hit_r] + 1'b1 : refs_r[hit_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        cond_r[k] <= COND_EMPTY; refs_r[k] <= '0; last_r[k] <= '0;
      end
    end else if (cmd.commit) begin
      res_vv <= 1'b0; res_vb <= '0; res_refs <= '0; res_slot <= '0;
      case (req_r)
        REQ_LOAD: begin
          if (hit_f_r) begin
            refs_r[hit_r] <= hr; last_r[hit_r] <= now_r;
            res_status <= (cond_r[hit_r] == COND_CLEAN || cond_r[hit_r] == COND_DIRTY) ?
                          ST_HIT_READY : ST_HIT_LOADING;
            res_slot <= 4'(hit_r); res_refs <= hr;
          end else if (emp_f_r || vic_f_r) begin
            cond_r[ld] <= COND_LOADING; blk_r[ld] <= bn_r;
            refs_r[ld] <= REFS_W'(1); last_r[ld] <= now_r;
            res_slot <= 4'(ld); res_refs <= REFS_W'(1);
            res_status <= emp_f_r ? ST_FILL_EMPTY : ST_FILL_EVICT;
            if (!emp_f_r) begin res_vv <= 1'b1; res_vb <= 32'(blk_r[ld]); end
          end else if (dty_f_r) begin
            res_status <= ST_NEED_SYNC; res_slot <= 4'(dty_r);
          end else res_status <= ST_NO_ROOM;
        end
        REQ_DROP: begin
          for (int k = 0; k < NUM_SLOTS; k++)
            if (refs_r[k] == '0) cond_r[k] <= COND_EMPTY;
          res_status <= ST_OK;
        end
        REQ_RELEASE, REQ_MARK_DIRTY, REQ_FILL_DONE, REQ_WRITE_DONE: begin
          res_slot <= sel_r;
          res_status <= ST_ERROR;
          if (sel_ok) begin
            res_refs <= refs_r[s];
            case (req_r)
              REQ_RELEASE: begin
                if (refs_r[s] == '0) res_refs <= '0;
                else begin
                  refs_r[s] <= refs_r[s] - 1'b1; last_r[s] <= now_r;
                  res_refs <= refs_r[s] - 1'b1; res_status <= ST_OK;
                end
              end
              REQ_MARK_DIRTY:
                if (cond_r[s] == COND_CLEAN || cond_r[s] == COND_DIRTY) begin
                  cond_r[s] <= COND_DIRTY; res_status <= ST_OK;
                end
              REQ_FILL_DONE:
                if (cond_r[s] == COND_ALLOCATED || cond_r[s] == COND_LOADING) begin
                  cond_r[s] <= COND_CLEAN; res_status <= ST_OK;
                end
              default:
                if (cond_r[s] == COND_DIRTY) begin
                  cond_r[s] <= COND_CLEAN; res_status <= ST_OK;
                end
            endcase
          end
        end
        default: res_status <= ST_ERROR;
      endcase
    end
  end
endmodule

>>> hdl/block_cache_slot_manager.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields (low bit first)
// in_      in   tdata: req_type[2:0] block_number[34:3] slot_select[38:35] time_stamp[70:39]
// out_     out  tdata: status[2:0] slot[6:3] victim_valid[7] victim_block[39:8]
//                      refs_after[55:40]
// Each request runs through accept, a scan of all 16 slots, and commit.
// The scan walks one slot per cycle; the commit writes the slot table and the
// output register. Reset is synchronous and empties every slot at once.
// A stalled output holds the commit; no request is taken until it completes.
module block_cache_slot_manager
  import bcsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // req_type, block_number, slot_select, time_stamp
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // status, slot, victim_valid, victim_block, refs_after
);
  cmd_t cmd;
  sts_t sts;
  logic in_fire, out_valid_r;
  logic [2:0] st; logic [3:0] sl; logic vv; logic [31:0] vb; logic [15:0] rf;

  assign in_fire = in_tvalid && in_tready;

  bcsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(out_valid_r && !out_tready),
    .sts(sts), .cmd(cmd), .in_ready(in_tready)
  );

  bcsm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req(in_tdata[2:0]), .in_block(in_tdata[34:3]),
    .in_sel(in_tdata[38:35]), .in_time(in_tdata[70:39]),
    .res_status(st), .res_slot(sl), .res_vv(vv), .res_vb(vb), .res_refs(rf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.commit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {rf, vb, vv, sl, st};

  a_no_commit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_tready)) else $error("commit over held output");
  a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid) else $error("result lost");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("accept during scan");
endmodule
